### sv/tfe_pkg.sv
package tfe_pkg;

   localparam logic [7:0] START_MARK       = 8'h7E;
   localparam logic [7:0] ESC_MARK         = 8'h7D;
   localparam logic [7:0] ESC_XOR          = 8'h20;
   localparam logic [7:0] EMPTY_FRAME_TYPE = 8'h00;
   localparam logic [7:0] RESET_FRAME_TYPE = 8'h10;
   localparam logic [7:0] ESC_START_BYTE   = 8'h5E;
   localparam logic [7:0] ESC_ESC_BYTE     = 8'h5D;

   localparam int unsigned FRAME_BYTES = 8;
   localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

   typedef enum logic [1:0] {
      ACT_HEADER = 2'd0,
      ACT_DATA   = 2'd1,
      ACT_EMPTY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SENSOR,
      ST_FRAME,
      ST_ESC
   } state_type;

endpackage

### sv/telemetry_frame_encoder_unit.sv
// Telemetry frame encoder.
// req_ channel: one command word (header, data frame or empty frame).
// rsp_ channel: the wire bytes, one per word, tlast on the final byte.
// csr_ channel: frame type byte used by data frames; write only while idle.
// A header gives 2 words; a frame gives 8 bytes plus one extra word per
// byte that needs escaping, so 8 to 16 words. An unused action code is
// accepted and gives no word.
// A small sequencer walks the eight frame bytes through one shared
// end-around-carry adder and one escape compare, one word per cycle.
// After acceptance the sequencer leaves idle and then loads the first word
// into the output register; req_tready returns on the same edge that loads
// the last word into the output register.
// When rsp_tready is low the output register holds its word and the
// sequencer waits; nothing is dropped.
// Reset clears the sequencer and output valid, and sets the frame type
// to 0x10.
module telemetry_frame_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // sensor_id[7:0], data_type_id[23:8], value[55:24]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // tx_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   tfe_pkg::state_type state_ff, state_in;
   logic [tfe_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic [55:0] shift_ff, shift_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  pend_ff, pend_in;
   logic        pend_last_ff, pend_last_in;
   logic [7:0]  frame_type_ff;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   logic        out_free;
   logic        req_fire;
   logic        is_cksum;
   logic [7:0]  cur_byte;
   logic        need_esc;
   logic [8:0]  add_sum;
   tfe_pkg::action_type act;

   assign req_tready = (state_ff == tfe_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign act        = tfe_pkg::action_type'(req_tuser);

   assign is_cksum = (idx_ff == tfe_pkg::IDX_W'(tfe_pkg::FRAME_BYTES - 1));
   assign cur_byte = is_cksum ? ~sum_ff : shift_ff[7:0];
   assign need_esc = (cur_byte == tfe_pkg::START_MARK) || (cur_byte == tfe_pkg::ESC_MARK);
   assign add_sum  = {1'b0, sum_ff} + {1'b0, cur_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tfe_pkg::ST_IDLE;
         idx_ff        <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
         frame_type_ff <= tfe_pkg::RESET_FRAME_TYPE;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            frame_type_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      id_ff        <= id_in;
      pend_ff      <= pend_in;
      pend_last_ff <= pend_last_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      shift_in     = shift_ff;
      id_in        = id_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         tfe_pkg::ST_IDLE: begin
            if (req_fire) begin
               id_in  = req_tdata[7:0];
               idx_in = '0;
               unique case (act)
                  tfe_pkg::ACT_HEADER: state_in = tfe_pkg::ST_MARK;
                  tfe_pkg::ACT_DATA: begin
                     shift_in = {req_tdata[55:24], req_tdata[23:8], frame_type_ff};
                     state_in = tfe_pkg::ST_FRAME;
                  end
                  tfe_pkg::ACT_EMPTY: begin
                     shift_in = {32'h0, req_tdata[23:8], tfe_pkg::EMPTY_FRAME_TYPE};
                     state_in = tfe_pkg::ST_FRAME;
                  end
                  default: state_in = tfe_pkg::ST_IDLE;
               endcase
            end
         end
         tfe_pkg::ST_MARK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = tfe_pkg::START_MARK;
               out_last_in  = 1'b0;
               state_in     = tfe_pkg::ST_SENSOR;
            end
         end
         tfe_pkg::ST_SENSOR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = id_ff;
               out_last_in  = 1'b1;
               state_in     = tfe_pkg::ST_IDLE;
            end
         end
         tfe_pkg::ST_FRAME: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               shift_in     = {8'h00, shift_ff[55:8]};
               idx_in       = idx_ff + 1'b1;
               sum_in       = is_cksum ? 8'h00 : (add_sum[7:0] + {7'b0, add_sum[8]});
               if (need_esc) begin
                  out_data_in  = tfe_pkg::ESC_MARK;
                  out_last_in  = 1'b0;
                  pend_in      = cur_byte ^ tfe_pkg::ESC_XOR;
                  pend_last_in = is_cksum;
                  state_in     = tfe_pkg::ST_ESC;
               end else begin
                  out_data_in = cur_byte;
                  out_last_in = is_cksum;
                  state_in    = is_cksum ? tfe_pkg::ST_IDLE : tfe_pkg::ST_FRAME;
               end
            end
         end
         tfe_pkg::ST_ESC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = pend_ff;
               out_last_in  = pend_last_ff;
               state_in     = pend_last_ff ? tfe_pkg::ST_IDLE : tfe_pkg::ST_FRAME;
            end
         end
         default: state_in = tfe_pkg::ST_IDLE;
      endcase
   end

   a_sum_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfe_pkg::ST_IDLE) |-> (sum_ff == 8'h00))
      else $error("checksum not cleared between commands");

   a_esc_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfe_pkg::ST_ESC && out_valid_ff) |-> (out_data_ff == tfe_pkg::ESC_MARK))
      else $error("escape pair second half without escape mark");

   a_esc_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfe_pkg::ST_ESC) |->
         (pend_ff == tfe_pkg::ESC_START_BYTE || pend_ff == tfe_pkg::ESC_ESC_BYTE))
      else $error("bad escaped byte");

   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |->
         (state_ff != tfe_pkg::ST_SENSOR && state_ff != tfe_pkg::ST_ESC))
      else $error("last word held in mid command");

endmodule
